// ===== rtl/core/ala_pkg.sv =====
// Shared types and constants for the address lease allocator.
// Used by ala_ctrl, ala_dp and the address_lease_allocator top level.
package ala_pkg;

    // Item opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W   = 1;
    localparam logic [0:0] CFG_NETWORK = 1'd0;
    localparam logic [0:0] CFG_PREFIX  = 1'd1;
    localparam logic [4:0] PREFIX_RST  = 5'd24;

    // Reserved host selects, taken in this order after a clear
    localparam logic [1:0] RSV_NETWORK  = 2'd0;
    localparam logic [1:0] RSV_BCAST_X1 = 2'd1;
    localparam logic [1:0] RSV_BCAST    = 2'd2;

    // Input item
    typedef struct packed {
        logic        opcode;
        logic [31:0] address;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] leased_address;
        logic [8:0]  free_count;
    } t_out_item;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NONE,
        DP_CLEAR,
        DP_TAKE_RSV,
        DP_ACCEPT,
        DP_WALK_RD,
        DP_WALK_CHK,
        DP_LEAF_WR,
        DP_UP_RD,
        DP_UP_WR,
        DP_FREE_RD,
        DP_FREE_CHK,
        DP_FREE_CLR
    } t_dp_op;

    typedef struct packed {
        t_dp_op      op;
        logic [1:0]  rsv_sel;
        logic        res_load;
        logic [1:0]  res_status;
        logic        res_grant;
    } t_dp_cmd;

    typedef struct packed {
        logic cfg_hit;
        logic clr_last;
        logic lev_last;
        logic node_root;
        logic free_last;
        logic root_full;
        logic leaf_set;
    } t_dp_sts;

endpackage

// ===== rtl/core/ala_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ala_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ala_ctrl.sv =====
// Sequencer for the address lease allocator: clear pass, reserved takes,
// allocate walk and free path. Depends on ala_pkg; drives ala_dp.
module ala_ctrl
    import ala_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_opcode,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_RSV      = 12'b0000_0000_0010,
        S_IDLE     = 12'b0000_0000_0100,
        S_WALK_RD  = 12'b0000_0000_1000,
        S_WALK_CHK = 12'b0000_0001_0000,
        S_LEAF_WR  = 12'b0000_0010_0000,
        S_UP_RD    = 12'b0000_0100_0000,
        S_UP_WR    = 12'b0000_1000_0000,
        S_FREE_RD  = 12'b0001_0000_0000,
        S_FREE_CHK = 12'b0010_0000_0000,
        S_FREE_CLR = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_rsv, n_rsv;
    logic       r_init, n_init;
    logic [1:0] r_status, n_status;
    logic       r_grant, n_grant;
    logic       r_out_valid, n_out_valid;

    // Take items only when idle and no configuration write is arriving
    assign o_in_stall  = (r_state != S_IDLE) || i_sts.cfg_hit;
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_rsv       = r_rsv;
        n_init      = r_init;
        n_status    = r_status;
        n_grant     = r_grant;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd            = '0;
        o_cmd.op         = DP_NONE;
        o_cmd.rsv_sel    = r_rsv;
        o_cmd.res_status = r_status;
        o_cmd.res_grant  = r_grant;

        if (i_sts.cfg_hit) begin
            n_state = S_CLEAR;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    o_cmd.op = DP_CLEAR;
                    if (i_sts.clr_last) begin
                        n_state = S_RSV;
                        n_rsv   = RSV_NETWORK;
                        n_init  = 1'b1;
                    end
                end
                S_RSV: begin
                    o_cmd.op = DP_TAKE_RSV;
                    n_state  = S_WALK_RD;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        o_cmd.op = DP_ACCEPT;
                        n_grant  = 1'b0;
                        if (i_in_opcode == OP_FREE) begin
                            n_state = S_FREE_RD;
                        end else if (i_sts.root_full) begin
                            n_status = ST_NO_FREE;
                            n_state  = S_DONE;
                        end else begin
                            n_status = ST_OK;
                            n_grant  = 1'b1;
                            n_state  = S_WALK_RD;
                        end
                    end
                end
                S_WALK_RD: begin
                    o_cmd.op = DP_WALK_RD;
                    n_state  = S_WALK_CHK;
                end
                S_WALK_CHK: begin
                    o_cmd.op = DP_WALK_CHK;
                    n_state  = i_sts.lev_last ? S_LEAF_WR : S_WALK_RD;
                end
                S_LEAF_WR: begin
                    o_cmd.op = DP_LEAF_WR;
                    n_state  = S_UP_RD;
                end
                S_UP_RD: begin
                    o_cmd.op = DP_UP_RD;
                    n_state  = S_UP_WR;
                end
                S_UP_WR: begin
                    o_cmd.op = DP_UP_WR;
                    if (!i_sts.node_root) begin
                        n_state = S_UP_RD;
                    end else if (!r_init) begin
                        n_state = S_DONE;
                    end else if (r_rsv == RSV_BCAST) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_rsv   = r_rsv + 2'd1;
                        n_state = S_RSV;
                    end
                end
                S_FREE_RD: begin
                    o_cmd.op = DP_FREE_RD;
                    n_state  = S_FREE_CHK;
                end
                S_FREE_CHK: begin
                    o_cmd.op = DP_FREE_CHK;
                    if (i_sts.leaf_set) begin
                        n_status = ST_OK;
                        n_state  = S_FREE_CLR;
                    end else begin
                        n_status = ST_INVALID;
                        n_state  = S_DONE;
                    end
                end
                S_FREE_CLR: begin
                    o_cmd.op = DP_FREE_CLR;
                    if (i_sts.free_last) begin
                        n_state = S_DONE;
                    end
                end
                S_DONE: begin
                    // Load the output register once it is empty or draining
                    if (!r_out_valid || !i_out_stall) begin
                        o_cmd.res_load = 1'b1;
                        n_out_valid    = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_CLEAR;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rsv       <= RSV_NETWORK;
            r_init      <= 1'b0;
            r_status    <= ST_OK;
            r_grant     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsv       <= n_rsv;
            r_init      <= n_init;
            r_status    <= n_status;
            r_grant     <= n_grant;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/ala_dp.sv =====
// Datapath for the address lease allocator: configuration registers, leaf
// bitmap and full-flag tree memories, walk registers and result register.
// Depends on ala_pkg and ala_ram; commanded by ala_ctrl.
module ala_dp
    import ala_pkg::*;
#(
    parameter int HOST_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  t_in_item             i_in_data,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int NW    = HOST_BITS + 1;          // heap node index width
    localparam int LW    = $clog2(HOST_BITS + 1);  // level count width
    localparam int HIW   = $clog2(HOST_BITS);      // host bit index width
    localparam int DEPTH = 1 << HOST_BITS;
    localparam logic [HOST_BITS-1:0] HOST_ONE = HOST_BITS'(1);
    localparam logic [NW-1:0]        NODE_ONE = NW'(1);
    localparam logic [LW-1:0]        LEV_ONE  = LW'(1);

    logic [31:0]          r_network;
    logic [4:0]           r_prefix;
    logic [HOST_BITS-1:0] r_clr_addr;
    logic                 r_root_full;
    logic [NW-1:0]        r_count;
    logic [HOST_BITS-1:0] r_host;
    logic [NW-1:0]        r_node;
    logic [NW-1:0]        r_child;
    logic [LW-1:0]        r_lev;
    logic                 r_cf;
    logic                 r_up_first;
    t_out_item            r_out;

    logic [5:0]           host_len;
    logic [LW-1:0]        host_l;
    logic [HOST_BITS-1:0] hbit_mask;
    logic [NW-1:0]        leaf_base;
    logic [HOST_BITS-1:0] in_host;
    logic [HOST_BITS-1:0] rsv_host;
    logic [31:0]          base_addr;
    logic [31:0]          count_wide;
    logic [LW-1:0]        lev_m1;
    logic [HIW-1:0]       bit_idx;
    logic [NW-1:0]        walk_child;
    logic                 lev_last;
    logic                 walk_full;
    logic [NW-1:0]        node_par;
    logic                 up_flag;
    logic                 cfg_hit;

    logic                 leaf_we, leaf_wdata, leaf_rdata;
    logic [HOST_BITS-1:0] leaf_waddr, leaf_raddr;
    logic                 tree_we, tree_wdata, tree_rdata;
    logic [HOST_BITS-1:0] tree_waddr, tree_raddr;

    assign o_cfg_ready = 1'b1;

    // Host bit count from the prefix, held to 2..HOST_BITS
    always_comb begin
        host_len = 6'd32 - {1'b0, r_prefix};
        if (host_len > 6'(HOST_BITS)) begin
            host_len = 6'(HOST_BITS);
        end else if (host_len < 6'd2) begin
            host_len = 6'd2;
        end
        host_l = host_len[LW-1:0];
    end

    // Host mask and first leaf node index
    always_comb begin
        for (int i = 0; i < HOST_BITS; i++) begin
            hbit_mask[i] = (LW'(i) < host_l);
        end
        for (int i = 0; i < NW; i++) begin
            leaf_base[i] = (LW'(i) == host_l);
        end
    end

    assign in_host   = i_in_data.address[HOST_BITS-1:0] & hbit_mask;
    assign base_addr = r_network & ~32'(hbit_mask);
    assign count_wide = 32'(r_count);

    // Reserved host for the clear sequence
    always_comb begin
        case (i_cmd.rsv_sel)
            RSV_NETWORK:  rsv_host = '0;
            RSV_BCAST_X1: rsv_host = hbit_mask ^ HOST_ONE;
            RSV_BCAST:    rsv_host = hbit_mask;
            default:      rsv_host = '0;
        endcase
    end

    // Walk and climb helpers
    assign lev_m1     = r_lev - LEV_ONE;
    assign bit_idx    = lev_m1[HIW-1:0];
    assign walk_child = {r_node[NW-2:0], r_host[bit_idx]};
    assign lev_last   = (r_lev == LEV_ONE);
    assign walk_full  = lev_last ? leaf_rdata : tree_rdata;
    assign node_par   = r_node >> 1;
    assign up_flag    = r_cf & (r_up_first ? leaf_rdata : tree_rdata);
    assign cfg_hit    = i_cfg_valid && o_cfg_ready;

    // Memory port steering
    always_comb begin
        leaf_we    = 1'b0;
        leaf_waddr = r_host;
        leaf_wdata = 1'b0;
        leaf_raddr = r_host;
        tree_we    = 1'b0;
        tree_waddr = r_node[HOST_BITS-1:0];
        tree_wdata = 1'b0;
        tree_raddr = walk_child[HOST_BITS-1:0];
        case (i_cmd.op)
            DP_CLEAR: begin
                leaf_we    = 1'b1;
                leaf_waddr = r_clr_addr;
                tree_we    = 1'b1;
                tree_waddr = r_clr_addr;
            end
            DP_LEAF_WR: begin
                leaf_we    = 1'b1;
                leaf_wdata = 1'b1;
            end
            DP_UP_RD: begin
                leaf_raddr = r_host ^ HOST_ONE;
                tree_raddr = r_child[HOST_BITS-1:0] ^ HOST_ONE;
            end
            DP_UP_WR: begin
                tree_we    = 1'b1;
                tree_wdata = up_flag;
            end
            DP_FREE_CHK: begin
                leaf_we = leaf_rdata;
            end
            DP_FREE_CLR: begin
                tree_we    = 1'b1;
                tree_waddr = node_par[HOST_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    ala_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (leaf_wdata),
        .i_raddr (leaf_raddr),
        .o_rdata (leaf_rdata)
    );

    ala_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_tree_ram (
        .i_clk   (i_clk),
        .i_we    (tree_we),
        .i_waddr (tree_waddr),
        .i_wdata (tree_wdata),
        .i_raddr (tree_raddr),
        .o_rdata (tree_rdata)
    );

    // Configuration, clear sweep, root flag mirror and free counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_network   <= '0;
            r_prefix    <= PREFIX_RST;
            r_clr_addr  <= '0;
            r_root_full <= 1'b0;
            r_count     <= '0;
        end else if (cfg_hit) begin
            case (i_cfg_index)
                CFG_NETWORK: begin
                    r_network  <= i_cfg_data;
                    r_clr_addr <= '0;
                end
                CFG_PREFIX: begin
                    r_prefix   <= i_cfg_data[4:0];
                    r_clr_addr <= '0;
                end
                default: begin
                end
            endcase
        end else begin
            case (i_cmd.op)
                DP_CLEAR: begin
                    r_clr_addr  <= r_clr_addr + HOST_ONE;
                    r_root_full <= 1'b0;
                    r_count     <= {1'b0, hbit_mask} + NODE_ONE;
                end
                DP_LEAF_WR: begin
                    if (r_count != '0) begin
                        r_count <= r_count - NODE_ONE;
                    end
                end
                DP_UP_WR: begin
                    if (r_node == NODE_ONE) begin
                        r_root_full <= up_flag;
                    end
                end
                DP_FREE_CHK: begin
                    if (leaf_rdata) begin
                        r_count <= r_count + NODE_ONE;
                    end
                end
                DP_FREE_CLR: begin
                    if (node_par == NODE_ONE) begin
                        r_root_full <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_ACCEPT: begin
                r_host <= in_host;
                r_lev  <= host_l;
                r_node <= (i_in_data.opcode == OP_FREE) ? (leaf_base | {1'b0, in_host})
                                                        : NODE_ONE;
            end
            DP_TAKE_RSV: begin
                r_host <= rsv_host;
                r_lev  <= host_l;
                r_node <= NODE_ONE;
            end
            DP_WALK_CHK: begin
                // Requested half full: take the sibling half
                if (walk_full) begin
                    r_host <= r_host ^ (HOST_ONE << bit_idx);
                end
                if (!lev_last) begin
                    r_node <= walk_child ^ NW'(walk_full);
                end
                r_lev <= lev_m1;
            end
            DP_LEAF_WR: begin
                r_cf       <= 1'b1;
                r_up_first <= 1'b1;
            end
            DP_UP_WR: begin
                r_cf       <= up_flag;
                r_child    <= r_node;
                r_node     <= node_par;
                r_up_first <= 1'b0;
            end
            DP_FREE_CLR: begin
                r_node <= node_par;
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out.status         <= i_cmd.res_status;
            r_out.leased_address <= i_cmd.res_grant ? (base_addr | 32'(r_host)) : '0;
            r_out.free_count     <= count_wide[8:0];
        end
    end

    assign o_out_data = r_out;

    assign o_sts.cfg_hit   = cfg_hit;
    assign o_sts.clr_last  = &r_clr_addr;
    assign o_sts.lev_last  = lev_last;
    assign o_sts.node_root = (r_node == NODE_ONE);
    assign o_sts.free_last = (node_par == NODE_ONE);
    assign o_sts.root_full = r_root_full;
    assign o_sts.leaf_set  = leaf_rdata;

endmodule

// ===== rtl/core/address_lease_allocator.sv =====
// Address lease allocator top level: joins the ala_ctrl sequencer and the
// ala_dp datapath. Depends on ala_pkg, ala_ctrl, ala_dp and ala_ram.
//
// Leases host addresses of one subnet, one item at a time. With L host bits
// (32 minus the prefix, held to 2..HOST_BITS), an allocate walks down the L
// tree levels (read a full flag, then decide) and climbs back to the root
// (read the sibling flag, then write), as set by the single read port of each
// flag memory. A free reads and checks the leaf flag and, when the address is
// leased, clears the full flags up to the root; an allocate into a full tree
// gets the no-free status without a walk. After reset and after every
// configuration write the block sweeps all 2^HOST_BITS entries of both flag
// memories and then reserves the network, broadcast and broadcast-xor-1
// hosts, stalling input meanwhile.
// A new item is taken while the previous result still waits in the output
// register.
module address_lease_allocator
    import ala_pkg::*;
#(
    parameter int HOST_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer
    ala_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_opcode (i_in_data.opcode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // Datapath with flag memories
    ala_dp #(.HOST_BITS(HOST_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
